// ===== rtl/core/bdp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdp_pkg
// Shared item types, operation codes and status codes for the bounded deque
// with positional access.
// ----------------------------------------------------------------------------
`default_nettype none

package bdp_pkg;

  // Fixed field widths of the item channels
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OCC_W   = 5;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_INS_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REM_HEAD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_TAIL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INS_IDX  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REM_IDX  = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Kind of slot movement applied by one operation
  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_INS,
    SHIFT_REM
  } shift_e;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value_in;
    logic [IDX_W-1:0]          index;
  } bdp_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [OCC_W-1:0]          occupancy;
  } bdp_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_deque_positional_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_positional_unit
// Bounded ordered list of signed values with insert and remove at the head,
// the tail or an index; one result item per input item.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   in      | to block  | in_valid_i / in_ready_o   | in_data_i  (bdp_in_t)
//   out     | from block| out_valid_o / out_ready_i | out_data_o (bdp_out_t)
//
// One item per cycle while out_ready_i holds: an accepted item sits in the
// input register, executes against the slot array, and its result lands in
// the output register.
// Reset clears the valid bits and the element count; slot contents are
// not reset and are only read below the count.
// When out_ready_i is low the result holds, one more item waits in the
// input register, and in_ready_o then drops.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_positional_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bdp_pkg::bdp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bdp_pkg::bdp_out_t  out_data_o
);
  import bdp_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                in_valid_q;
  bdp_in_t             item_q;
  logic                out_valid_q;
  bdp_out_t            out_q;
  bdp_out_t            out_d;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     count_d;
  logic                advance;
  logic                exec;
  shift_e              shift;
  logic [SlotW-1:0]    pos;
  logic [STAT_W-1:0]   status;
  logic signed [VALUE_W-1:0] rd_data;

  // Move forward whenever the output register is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign exec       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  bdp_decode #(
    .CAPACITY (CAPACITY)
  ) u_decode (
    .item_i   (item_q),
    .count_i  (count_q),
    .shift_o  (shift),
    .pos_o    (pos),
    .status_o (status),
    .count_o  (count_d)
  );

  bdp_store #(
    .CAPACITY (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .en_i      (exec),
    .shift_i   (shift),
    .pos_i     (pos),
    .wr_data_i (item_q.value_in),
    .rd_data_o (rd_data)
  );

  // Advance the element count on execution
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (exec) begin
      count_q <= count_d;
    end
  end

  // Build the result item
  always_comb begin
    out_d.status        = status;
    out_d.removed_value = (shift == SHIFT_REM) ? rd_data : '0;
    out_d.occupancy     = OCC_W'(count_d);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/bdp_decode.sv =====
// ----------------------------------------------------------------------------
// bdp_decode
// Turns one item and the current element count into a slot position, a
// shift kind, a status code and the next element count.
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_decode #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW  = $clog2(CAPACITY + 1),
  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  bdp_pkg::bdp_in_t         item_i,
  input  logic [CntW-1:0]          count_i,
  output bdp_pkg::shift_e          shift_o,
  output logic [SlotW-1:0]         pos_o,
  output logic [bdp_pkg::STAT_W-1:0] status_o,
  output logic [CntW-1:0]          count_o
);
  import bdp_pkg::*;

  // Common width for comparing the index against the count
  localparam int unsigned CmpW = (CntW > IDX_W) ? CntW : IDX_W;

  logic [CmpW-1:0] idx_ext;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] last_pos;
  logic [CmpW-1:0] ins_idx_pos;
  logic [CmpW-1:0] rem_idx_pos;
  logic [CmpW-1:0] pos_wide;
  logic            is_full;
  logic            is_empty;
  logic            do_ins;
  logic            do_rem;

  assign idx_ext  = CmpW'(item_i.index);
  assign cnt_ext  = CmpW'(count_i);
  assign last_pos = cnt_ext - CmpW'(1);
  assign is_full  = (count_i == CntW'(CAPACITY));
  assign is_empty = (count_i == '0);

  // Clamp the index: insert appends past the end, remove takes the last one
  assign ins_idx_pos = (idx_ext > cnt_ext) ? cnt_ext : idx_ext;
  assign rem_idx_pos = (idx_ext >= cnt_ext) ? last_pos : idx_ext;

  // Pick position and operation class from the mode
  always_comb begin
    pos_wide = '0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    case (item_i.mode)
      MODE_INS_HEAD: begin
        do_ins = 1'b1;
      end
      MODE_INS_TAIL: begin
        do_ins   = 1'b1;
        pos_wide = cnt_ext;
      end
      MODE_REM_HEAD: begin
        do_rem = 1'b1;
      end
      MODE_REM_TAIL: begin
        do_rem   = 1'b1;
        pos_wide = last_pos;
      end
      MODE_INS_IDX: begin
        do_ins   = 1'b1;
        pos_wide = ins_idx_pos;
      end
      MODE_REM_IDX: begin
        do_rem   = 1'b1;
        pos_wide = rem_idx_pos;
      end
      default: begin
        pos_wide = '0;
      end
    endcase
  end

  // Refuse inserts on a full list and removals on an empty one
  always_comb begin
    shift_o  = SHIFT_NONE;
    status_o = ST_OK;
    count_o  = count_i;
    if (do_ins) begin
      if (is_full) begin
        status_o = ST_FULL;
      end else begin
        shift_o = SHIFT_INS;
        count_o = count_i + CntW'(1);
      end
    end else if (do_rem) begin
      if (is_empty) begin
        status_o = ST_EMPTY;
      end else begin
        shift_o = SHIFT_REM;
        count_o = count_i - CntW'(1);
      end
    end
  end

  // Valid positions always fit the slot index when a shift happens
  assign pos_o = pos_wide[SlotW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/bdp_store.sv =====
// ----------------------------------------------------------------------------
// bdp_store
// Register array of elements kept packed in order, head at slot zero. Each
// slot picks its next value from itself, its neighbor or the new value.
// ----------------------------------------------------------------------------
`default_nettype none

module bdp_store #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  bdp_pkg::shift_e                    shift_i,
  input  logic [SlotW-1:0]                   pos_i,
  input  logic signed [bdp_pkg::VALUE_W-1:0] wr_data_i,
  output logic signed [bdp_pkg::VALUE_W-1:0] rd_data_o
);
  import bdp_pkg::*;

  logic signed [VALUE_W-1:0] slot_q [CAPACITY];
  logic signed [VALUE_W-1:0] slot_d [CAPACITY];

  // Select per slot: keep below the position; insert writes at it and shifts above, remove shifts at and above
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic signed [VALUE_W-1:0] from_lower;
    logic signed [VALUE_W-1:0] from_upper;

    if (i == 0) begin : g_first
      assign from_lower = slot_q[i];
    end else begin : g_lower
      assign from_lower = slot_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign from_upper = slot_q[i];
    end else begin : g_upper
      assign from_upper = slot_q[i+1];
    end

    always_comb begin
      slot_d[i] = slot_q[i];
      case (shift_i)
        SHIFT_INS: begin
          if (SlotW'(i) == pos_i) begin
            slot_d[i] = wr_data_i;
          end else if (SlotW'(i) > pos_i) begin
            slot_d[i] = from_lower;
          end
        end
        SHIFT_REM: begin
          if (SlotW'(i) >= pos_i) begin
            slot_d[i] = from_upper;
          end
        end
        default: begin
          slot_d[i] = slot_q[i];
        end
      endcase
    end

    // Hold unless an operation executes
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  // Element at the position, taken out by a removal
  assign rd_data_o = slot_q[pos_i];

endmodule

`default_nettype wire

// ===== sim/bdp_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdp_result_checker
// Watches both item channels of the bounded deque. It keeps its own copy of
// the ordered element list and the element count, works out the expected
// result for every accepted input item, and compares each accepted result
// item field by field against the oldest expectation.
// ----------------------------------------------------------------------------

module bdp_result_checker
  import bdp_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  bdp_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  bdp_out_t    out_data_i,
  output int unsigned fail_count_o,
  output int unsigned results_due_o
);

  // Shadow list, head at entry zero; only entries below elem_count are read
  logic signed [VALUE_W-1:0] elems_q [CAPACITY];
  int unsigned               elem_count;
  bdp_out_t                  due_results[$];
  int unsigned               fail_count;

  assign fail_count_o  = fail_count;
  assign results_due_o = due_results.size();

  // Insert at pos, clamped to the end of the list
  function automatic logic [STAT_W-1:0] list_insert(int unsigned pos,
                                                    logic signed [VALUE_W-1:0] value);
    int unsigned at;
    if (elem_count >= CAPACITY) return ST_FULL;
    at = (pos > elem_count) ? elem_count : pos;
    for (int unsigned i = elem_count; i > at; i--) elems_q[i] = elems_q[i-1];
    elems_q[at] = value;
    elem_count++;
    return ST_OK;
  endfunction

  // Remove at pos, clamped to the last element
  function automatic logic [STAT_W-1:0] list_remove(int unsigned pos,
                                                    output logic signed [VALUE_W-1:0] taken);
    int unsigned at;
    taken = '0;
    if (elem_count == 0) return ST_EMPTY;
    at = (pos >= elem_count) ? elem_count - 1 : pos;
    taken = elems_q[at];
    for (int unsigned i = at; i + 1 < elem_count; i++) elems_q[i] = elems_q[i+1];
    elem_count--;
    return ST_OK;
  endfunction

  // Apply one operation to the shadow list and return the result it causes
  function automatic bdp_out_t apply_list_op(bdp_in_t op);
    bdp_out_t                  res;
    logic signed [VALUE_W-1:0] taken;
    res   = '0;
    taken = '0;
    case (op.mode)
      MODE_INS_HEAD: res.status = list_insert(0, op.value_in);
      MODE_INS_TAIL: res.status = list_insert(elem_count, op.value_in);
      MODE_REM_HEAD: res.status = list_remove(0, taken);
      MODE_REM_TAIL: res.status = list_remove((elem_count == 0) ? 0 : elem_count - 1, taken);
      MODE_INS_IDX:  res.status = list_insert(32'(op.index), op.value_in);
      MODE_REM_IDX:  res.status = list_remove(32'(op.index), taken);
      default:       res.status = ST_OK;
    endcase
    res.removed_value = taken;
    res.occupancy     = elem_count[OCC_W-1:0];
    return res;
  endfunction

  // Predict on input items, compare on result items
  always @(posedge clk_i or negedge rst_ni) begin
    bdp_out_t want;
    if (!rst_ni) begin
      elem_count = 0;
      fail_count = 0;
      due_results.delete();
      for (int unsigned i = 0; i < CAPACITY; i++) elems_q[i] = '0;
    end else begin
      if (in_valid_i && in_ready_i) due_results.push_back(apply_list_op(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result item status=%0d removed=%0d occupancy=%0d",
                   $time, out_data_i.status, out_data_i.removed_value,
                   out_data_i.occupancy);
        end else begin
          want = due_results.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.removed_value !== want.removed_value ||
              out_data_i.occupancy !== want.occupancy) begin
            fail_count++;
            $display("%0t: mismatch expected status=%0d removed=%0d occupancy=%0d",
                     $time, want.status, want.removed_value, want.occupancy);
            $display("%0t:          actual   status=%0d removed=%0d occupancy=%0d",
                     $time, out_data_i.status, out_data_i.removed_value,
                     out_data_i.occupancy);
          end
        end
      end
    end
  end

endmodule

// ===== sim/bounded_deque_positional_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_positional_unit_tb
// Drives list operations into the bounded deque: a directed pass over empty
// removals, clamped indexes, extreme values and the spare modes, then random
// operations in phases that lean toward inserts or removals so the list runs
// full and empty. Both sides idle at random; the checker judges every result.
// ----------------------------------------------------------------------------

module bounded_deque_positional_unit_tb;
  import bdp_pkg::*;

  localparam int unsigned RANDOM_OPS   = 400;
  localparam int unsigned PHASE_LEN    = 30;
  localparam int unsigned MAX_IDLE     = 11;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Mode codes with no operation behind them
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  bdp_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bdp_out_t    out_data;
  int unsigned fail_count;
  int unsigned results_due;
  bit          no_idle_q = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  bounded_deque_positional_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  bdp_result_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  function automatic int unsigned idle_draw();
    return no_idle_q ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic bdp_in_t pack_op(logic [MODE_W-1:0] mode,
                                      logic signed [VALUE_W-1:0] value,
                                      logic [IDX_W-1:0] index);
    bdp_in_t op;
    op.mode     = mode;
    op.value_in = value;
    op.index    = index;
    return op;
  endfunction

  // Random operation; insert_pct leans the phase toward filling or draining
  function automatic bdp_in_t random_op(int unsigned insert_pct);
    bdp_in_t op;
    op.value_in = $urandom;
    op.index    = IDX_W'($urandom_range(0, 15));
    if ($urandom_range(0, 99) < 3) begin
      op.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_HI : MODE_SPARE_LO;
    end else if ($urandom_range(0, 99) < insert_pct) begin
      case ($urandom_range(0, 2))
        0:       op.mode = MODE_INS_HEAD;
        1:       op.mode = MODE_INS_TAIL;
        default: op.mode = MODE_INS_IDX;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       op.mode = MODE_REM_HEAD;
        1:       op.mode = MODE_REM_TAIL;
        default: op.mode = MODE_REM_IDX;
      endcase
    end
    return op;
  endfunction

  // Hold valid low for a random gap, then present the item until accepted
  task automatic send_op(bdp_in_t op);
    int unsigned gap;
    gap = idle_draw();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Stall the result side at random, once per result item
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = idle_draw();
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin
    int unsigned insert_pct;
    insert_pct = 85;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Removals on an empty list
    send_op(pack_op(MODE_REM_HEAD, 32'sd5, 4'd0));
    send_op(pack_op(MODE_REM_TAIL, -32'sd1, 4'd15));
    send_op(pack_op(MODE_REM_IDX, 32'sd0, 4'd15));
    // Inserts with extreme values and clamped indexes
    send_op(pack_op(MODE_INS_HEAD, 32'sh7FFF_FFFF, 4'd0));
    send_op(pack_op(MODE_INS_TAIL, 32'sh8000_0000, 4'd15));
    send_op(pack_op(MODE_INS_IDX, -32'sd1, 4'd1));
    send_op(pack_op(MODE_INS_IDX, 32'sd0, 4'd15));
    send_op(pack_op(MODE_INS_IDX, 32'sh5555_5555, 4'd0));
    send_op(pack_op(MODE_INS_IDX, 32'shAAAA_AAAA, 4'd3));
    // Spare modes leave the list alone
    send_op(pack_op(MODE_SPARE_LO, -32'sd1, 4'd15));
    send_op(pack_op(MODE_SPARE_HI, 32'sd0, 4'd0));
    // Removals: clamped index, middle, both ends, then drain
    send_op(pack_op(MODE_REM_IDX, 32'sd7, 4'd15));
    send_op(pack_op(MODE_REM_IDX, 32'sd0, 4'd1));
    send_op(pack_op(MODE_REM_HEAD, 32'sd0, 4'd0));
    send_op(pack_op(MODE_REM_TAIL, 32'sd0, 4'd0));
    send_op(pack_op(MODE_REM_IDX, 32'sd0, 4'd0));
    send_op(pack_op(MODE_REM_TAIL, 32'sd0, 4'd0));

    // Random phases: first one fills the list, later ones pick a lean
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % PHASE_LEN == 0) begin
        if (n != 0) begin
          case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
          endcase
        end
        no_idle_q = ($urandom_range(0, 3) == 0);
      end
      send_op(random_op(insert_pct));
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
